// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on a clock and disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/mlaeq_pkg.sv =====
// ---------------------------------------------------------------------------
// mlaeq_pkg
// types and fixed constants of the multilevel active/expired queue
// ---------------------------------------------------------------------------
package mlaeq_pkg;

  localparam int NUM_LEVELS_W = 5;
  localparam int LEVEL_OUT_W  = 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int CUR_LEVEL_W  = 5;
  localparam int BASE_PRIO_W  = 5;

  localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RESET = 5'd4;

  // register select bit (paddr[2])
  localparam logic REG_NUM_LEVELS = 1'b0;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic signed [CUR_LEVEL_W-1:0] LEVEL_EXPIRED = -5'sd1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PLAN = 3'b010,
    S_READ = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/mlaeq_ram.sv =====
// ---------------------------------------------------------------------------
// mlaeq_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module mlaeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/multilevel_active_expired_queue.sv =====
// ---------------------------------------------------------------------------
// multilevel_active_expired_queue
// task scheduler core: per-level active and expired fifos of task ids
// ---------------------------------------------------------------------------
// Usage:
//   command channel: drive mode/task_id/current_level/base_priority with
//   start; the beat is taken at a rising edge with start high and busy low.
//   mode 0 enqueues (current_level of -1 files the task in the expired fifo
//   at base_priority-1), mode 1 dequeues the front of the highest non-empty
//   active level, swapping banks once if every active fifo is empty.
//   result channel: one result beat per command, shown for exactly one cycle
//   with done high; the receiver cannot stall it.
//   sequence: an enqueue is planned in S_PLAN and answered from there; a
//   dequeue with a hit goes S_PLAN then S_READ for the registered read of
//   the task store ram; a dequeue that swaps banks makes one extra priority
//   search in S_PLAN first, and answers from S_PLAN when the swap finds
//   nothing. busy is high from acceptance until done is shown, so a new
//   command can be accepted in the cycle done is shown.
//   apb port: num_levels at address 0, written while the block is idle.
//   reset (rst, synchronous): all fifos empty, all banks 0, num_levels 4;
//   the task store itself is not cleared, fifo counts make it safe.
// ---------------------------------------------------------------------------
module multilevel_active_expired_queue #(
  parameter int MAX_LEVELS   = 16,
  parameter int FIFO_DEPTH   = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // command channel
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     mode,
  input  logic [TASK_ID_BITS-1:0]                  task_id,
  input  logic signed [mlaeq_pkg::CUR_LEVEL_W-1:0] current_level,
  input  logic [mlaeq_pkg::BASE_PRIO_W-1:0]        base_priority,
  // result channel
  output logic                                     done,
  output logic                                     task_valid,
  output logic [TASK_ID_BITS-1:0]                  task_out,
  output logic [mlaeq_pkg::LEVEL_OUT_W-1:0]        level_out,
  output logic                                     banks_swapped,
  output logic                                     overflow,
  // configuration
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [mlaeq_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [mlaeq_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [mlaeq_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                     pready
);

  `include "assert_macros.svh"

  localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int FIFO_W    = LVL_W + 1;
  localparam int NUM_FIFOS = 2 * MAX_LEVELS;
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W     = PTR_W + 1;
  localparam int ADDR_W    = FIFO_W + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  mlaeq_pkg::state_t state;

  logic [mlaeq_pkg::NUM_LEVELS_W-1:0] num_levels;
  logic [PTR_W-1:0]                   fifo_head   [NUM_FIFOS];
  logic [CNT_W-1:0]                   fifo_count  [NUM_FIFOS];
  logic                               active_bank [MAX_LEVELS];

  logic                                     mode_r;
  logic [TASK_ID_BITS-1:0]                  task_id_r;
  logic signed [mlaeq_pkg::CUR_LEVEL_W-1:0] current_level_r;
  logic [mlaeq_pkg::BASE_PRIO_W-1:0]        base_priority_r;
  logic                                     swapped_r;
  logic [LVL_W-1:0]                         lvl_r;

  logic [LVL_W-1:0]  top_lvl;
  logic              expired;
  logic signed [6:0] want;
  logic [LVL_W-1:0]  enq_lvl;
  logic [FIFO_W-1:0] enq_fifo;
  logic [CNT_W-1:0]  enq_cnt;
  logic              enq_full;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail_slot;
  logic              deq_found;
  logic [LVL_W-1:0]  deq_lvl;
  logic [FIFO_W-1:0] deq_fifo;
  logic [PTR_W-1:0]  deq_head;
  logic [PTR_W-1:0]  deq_head_next;
  logic              cfg_wr;
  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TASK_ID_BITS-1:0] ram_rdata;

  assign busy   = (state != mlaeq_pkg::S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == mlaeq_pkg::REG_NUM_LEVELS);
  assign prdata = (paddr[2] == mlaeq_pkg::REG_NUM_LEVELS) ?
                  mlaeq_pkg::CFG_DATA_W'(num_levels) : '0;

  // highest level index in use
  always_comb begin
    if (num_levels == '0) begin
      top_lvl = '0;
    end else if (32'(num_levels) > 32'(MAX_LEVELS)) begin
      top_lvl = LVL_W'(MAX_LEVELS - 1);
    end else begin
      top_lvl = LVL_W'(num_levels - 5'd1);
    end
  end

  // enqueue target
  always_comb begin
    expired = (current_level_r == mlaeq_pkg::LEVEL_EXPIRED);
    if (expired) begin
      want = $signed({2'b00, base_priority_r}) - 7'sd1;
    end else begin
      want = {{2{current_level_r[4]}}, current_level_r};
    end
    if (want < 7'sd0) begin
      enq_lvl = '0;
    end else if (32'(want[5:0]) > 32'(top_lvl)) begin
      enq_lvl = top_lvl;
    end else begin
      enq_lvl = LVL_W'(want[5:0]);
    end
    enq_fifo = {enq_lvl, active_bank[enq_lvl] ^ expired};
    enq_cnt  = fifo_count[enq_fifo];
    enq_full = (32'(enq_cnt) == 32'(FIFO_DEPTH));
    tail_sum = SUM_W'(fifo_head[enq_fifo]) + SUM_W'(enq_cnt);
    if (32'(tail_sum) >= 32'(FIFO_DEPTH)) begin
      tail_slot = PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH));
    end else begin
      tail_slot = PTR_W'(tail_sum);
    end
  end

  // priority encode over active fifo fills, highest level wins
  always_comb begin
    deq_found = 1'b0;
    deq_lvl   = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if ((32'(i) <= 32'(top_lvl)) &&
          (fifo_count[{LVL_W'(i), active_bank[i]}] != '0)) begin
        deq_found = 1'b1;
        deq_lvl   = LVL_W'(i);
      end
    end
    deq_fifo = {deq_lvl, active_bank[deq_lvl]};
    deq_head = fifo_head[deq_fifo];
    if (32'(deq_head) == 32'(FIFO_DEPTH - 1)) begin
      deq_head_next = '0;
    end else begin
      deq_head_next = deq_head + PTR_W'(1);
    end
  end

  assign ram_we    = (state == mlaeq_pkg::S_PLAN) && (mode_r == mlaeq_pkg::MODE_ENQ) &&
                     !enq_full;
  assign ram_waddr = {enq_fifo, tail_slot};
  assign ram_raddr = {deq_fifo, deq_head};

  mlaeq_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_task_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (task_id_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mlaeq_pkg::S_IDLE;
      done       <= 1'b0;
      swapped_r  <= 1'b0;
      num_levels <= mlaeq_pkg::NUM_LEVELS_RESET;
      for (int i = 0; i < NUM_FIFOS; i++) begin
        fifo_head[i]  <= '0;
        fifo_count[i] <= '0;
      end
      for (int i = 0; i < MAX_LEVELS; i++) begin
        active_bank[i] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        num_levels <= pwdata[mlaeq_pkg::NUM_LEVELS_W-1:0];
      end
      case (state)
        mlaeq_pkg::S_IDLE: begin
          if (accept) begin
            swapped_r <= 1'b0;
            state     <= mlaeq_pkg::S_PLAN;
          end
        end
        mlaeq_pkg::S_PLAN: begin
          if (mode_r == mlaeq_pkg::MODE_ENQ) begin
            if (!enq_full) begin
              fifo_count[enq_fifo] <= enq_cnt + CNT_W'(1);
            end
            done  <= 1'b1;
            state <= mlaeq_pkg::S_IDLE;
          end else if (deq_found) begin
            fifo_head[deq_fifo]  <= deq_head_next;
            fifo_count[deq_fifo] <= fifo_count[deq_fifo] - CNT_W'(1);
            state                <= mlaeq_pkg::S_READ;
          end else if (!swapped_r) begin
            // every active fifo in use is empty: flip all of them, search again
            for (int i = 0; i < MAX_LEVELS; i++) begin
              if (32'(i) <= 32'(top_lvl)) begin
                active_bank[i] <= !active_bank[i];
              end
            end
            swapped_r <= 1'b1;
          end else begin
            done  <= 1'b1;
            state <= mlaeq_pkg::S_IDLE;
          end
        end
        mlaeq_pkg::S_READ: begin
          done  <= 1'b1;
          state <= mlaeq_pkg::S_IDLE;
        end
        default: begin
          state <= mlaeq_pkg::S_IDLE;
        end
      endcase
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r          <= mode;
      task_id_r       <= task_id;
      current_level_r <= current_level;
      base_priority_r <= base_priority;
    end
    case (state)
      mlaeq_pkg::S_PLAN: begin
        if (mode_r == mlaeq_pkg::MODE_ENQ) begin
          task_valid    <= 1'b0;
          task_out      <= '0;
          level_out     <= mlaeq_pkg::LEVEL_OUT_W'(enq_lvl);
          banks_swapped <= 1'b0;
          overflow      <= enq_full;
        end else if (deq_found) begin
          lvl_r <= deq_lvl;
        end else begin
          // empty dequeue result, only shown once the second search missed
          task_valid    <= 1'b0;
          task_out      <= '0;
          level_out     <= '0;
          banks_swapped <= 1'b1;
          overflow      <= 1'b0;
        end
      end
      mlaeq_pkg::S_READ: begin
        task_valid    <= 1'b1;
        task_out      <= ram_rdata;
        level_out     <= mlaeq_pkg::LEVEL_OUT_W'(lvl_r);
        banks_swapped <= swapped_r;
        overflow      <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `ASSERT_IMP(a_done_after_busy, clk, rst, done, $past(busy))
  `ASSERT_NEXT(a_read_gives_task, clk, rst, state == mlaeq_pkg::S_READ, done && task_valid)

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// multilevel active/expired queue: a directed table of enqueue and dequeue
// commands, then random phases under several level counts, each result beat
// compared field by field against a scoreboard fed by an in-bench scheduler
// model; the sender idles in random bursts, the result side cannot stall
// ---------------------------------------------------------------------------
module testbench;

  localparam int LEVEL_CAP    = 16;
  localparam int FIFO_SLOTS   = 16;
  localparam int ID_W         = 8;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 75;
  localparam int DIR_ROWS     = 22;
  localparam int STALL_LIMIT  = 2000;
  localparam int DUE_SLOTS    = 64;

  localparam logic       CMD_ENQ     = mlaeq_pkg::MODE_ENQ;
  localparam logic       CMD_DEQ     = mlaeq_pkg::MODE_DEQ;
  localparam logic [4:0] LVL_EXPIRED = mlaeq_pkg::LEVEL_EXPIRED;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] tid;
    logic [4:0]      cur;
    logic [4:0]      base;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] tid;
    logic [3:0]      level;
    logic            swapped;
    logic            ovf;
  } res_t;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                      start = 1'b0;
  logic                                      busy;
  logic                                      mode = mlaeq_pkg::MODE_ENQ;
  logic [ID_W-1:0]                           task_id = '0;
  logic signed [mlaeq_pkg::CUR_LEVEL_W-1:0]  current_level = '0;
  logic [mlaeq_pkg::BASE_PRIO_W-1:0]         base_priority = '0;
  logic                                      done;
  logic                                      task_valid;
  logic [ID_W-1:0]                           task_out;
  logic [mlaeq_pkg::LEVEL_OUT_W-1:0]         level_out;
  logic                                      banks_swapped;
  logic                                      overflow;
  logic                                      psel = 1'b0;
  logic                                      penable = 1'b0;
  logic                                      pwrite = 1'b0;
  logic [mlaeq_pkg::CFG_ADDR_W-1:0]          paddr = '0;
  logic [mlaeq_pkg::CFG_DATA_W-1:0]          pwdata = '0;
  logic [mlaeq_pkg::CFG_DATA_W-1:0]          prdata;
  logic                                      pready;

  multilevel_active_expired_queue #(
    .MAX_LEVELS  (LEVEL_CAP),
    .FIFO_DEPTH  (FIFO_SLOTS),
    .TASK_ID_BITS(ID_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .task_id      (task_id),
    .current_level(current_level),
    .base_priority(base_priority),
    .done         (done),
    .task_valid   (task_valid),
    .task_out     (task_out),
    .level_out    (level_out),
    .banks_swapped(banks_swapped),
    .overflow     (overflow),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk = ~clk;

  // scheduler model state
  logic [ID_W-1:0] slot_mem [2*LEVEL_CAP][FIFO_SLOTS];
  int              fifo_rd [2*LEVEL_CAP];
  int              fifo_fill [2*LEVEL_CAP];
  bit              bank_sel [LEVEL_CAP];
  logic [4:0]      cfg_levels;

  // ring of results still owed by the block
  res_t due_ring [DUE_SLOTS];
  int   due_wr = 0;
  int   due_rd = 0;
  int   due_cnt = 0;
  int   mismatches = 0;
  int   burst_left = 0;

  function automatic void due_add(input res_t r);
    due_ring[due_wr] = r;
    due_wr = (due_wr + 1) % DUE_SLOTS;
    due_cnt++;
  endfunction

  function automatic res_t due_take();
    res_t r;
    r = due_ring[due_rd];
    due_rd = (due_rd + 1) % DUE_SLOTS;
    due_cnt--;
    return r;
  endfunction

  // serve the front of the highest non-empty active fifo
  function automatic bit pop_top(input int lv, output logic [ID_W-1:0] tid,
                                 output logic [3:0] lvl);
    int f;
    for (int i = lv - 1; i >= 0; i--) begin
      f = 2 * i + bank_sel[i];
      if (fifo_fill[f] > 0) begin
        tid = slot_mem[f][fifo_rd[f]];
        fifo_rd[f] = (fifo_rd[f] + 1) % FIFO_SLOTS;
        fifo_fill[f]--;
        lvl = 4'(i);
        return 1'b1;
      end
    end
    tid = '0;
    lvl = '0;
    return 1'b0;
  endfunction

  function automatic res_t sched_step(input cmd_t c);
    int   lv;
    int   want;
    int   f;
    bit   expired;
    bit   found;
    res_t r;
    r = '0;
    if (cfg_levels == 0) lv = 1;
    else if (cfg_levels > LEVEL_CAP) lv = LEVEL_CAP;
    else lv = int'(cfg_levels);
    if (c.mode == CMD_ENQ) begin
      expired = (c.cur == LVL_EXPIRED);
      want = expired ? int'(c.base) - 1 : int'($signed(c.cur));
      if (want < 0) want = 0;
      if (want >= lv) want = lv - 1;
      r.level = 4'(want);
      f = 2 * want + (expired ? int'(!bank_sel[want]) : int'(bank_sel[want]));
      if (fifo_fill[f] >= FIFO_SLOTS) begin
        r.ovf = 1'b1;
      end else begin
        slot_mem[f][(fifo_rd[f] + fifo_fill[f]) % FIFO_SLOTS] = c.tid;
        fifo_fill[f]++;
      end
    end else begin
      found = pop_top(lv, r.tid, r.level);
      if (!found) begin
        // every active fifo empty: flip the empty levels and look again
        for (int i = 0; i < lv; i++) begin
          if (fifo_fill[2 * i + bank_sel[i]] == 0) bank_sel[i] = ~bank_sel[i];
        end
        r.swapped = 1'b1;
        found = pop_top(lv, r.tid, r.level);
      end
      r.valid = found;
    end
    return r;
  endfunction

  task automatic issue(input cmd_t c, input logic typed, input res_t typed_res);
    res_t e;
    start         <= 1'b1;
    mode          <= c.mode;
    task_id       <= c.tid;
    current_level <= c.cur;
    base_priority <= c.base;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = sched_step(c);
    due_add(typed ? typed_res : e);
  endtask

  // sender bursts, gaps and the odd full drain
  task automatic pace();
    int gap;
    bit drain;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      drain = ($urandom_range(0, 24) == 0);
      if (gap > 0 || drain) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (drain) begin
        @(posedge clk);
        while (due_cnt != 0) @(posedge clk);
      end
    end
  endtask

  task automatic write_levels(input logic [4:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (due_cnt != 0 || busy) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mlaeq_pkg::REG_NUM_LEVELS, 2'b00};
    pwdata  <= {27'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_levels = val;
  endtask

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && done) begin
      got = '{task_valid, task_out, level_out, banks_swapped, overflow};
      if (due_cnt == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("extra beat: valid=%0d task=%h level=%0d swapped=%0d ovf=%0d",
                   got.valid, got.tid, got.level, got.swapped, got.ovf);
      end else begin
        want = due_take();
        if (got.valid !== want.valid || got.tid !== want.tid ||
            got.level !== want.level || got.swapped !== want.swapped ||
            got.ovf !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected valid=%0d task=%h level=%0d swapped=%0d ovf=%0d",
                     want.valid, want.tid, want.level, want.swapped, want.ovf);
            $display("          got      valid=%0d task=%h level=%0d swapped=%0d ovf=%0d",
                     got.valid, got.tid, got.level, got.swapped, got.ovf);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    dir_row_t   dir_tab [DIR_ROWS];
    logic [4:0] phase_lv [NUM_PHASES];
    cmd_t       c;
    cmd_t       fill_cmd;
    int         fill_left;
    int         pick;

    for (int f = 0; f < 2 * LEVEL_CAP; f++) begin
      fifo_rd[f] = 0;
      fifo_fill[f] = 0;
    end
    for (int l = 0; l < LEVEL_CAP; l++) bank_sel[l] = 1'b0;
    cfg_levels = mlaeq_pkg::NUM_LEVELS_RESET;
    fill_left = 0;
    fill_cmd = '0;

    // four levels after reset; typed rows can be read off by hand
    dir_tab[0]  = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b1, 1'b0}};
    dir_tab[1]  = '{'{CMD_ENQ, 8'hFF, 5'd15, 5'd1}, 1'b1, '{1'b0, 8'h00, 4'd3, 1'b0, 1'b0}};
    dir_tab[2]  = '{'{CMD_ENQ, 8'h00, 5'd0, 5'd16}, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b0, 1'b0}};
    dir_tab[3]  = '{'{CMD_ENQ, 8'hA5, LVL_EXPIRED, 5'd16}, 1'b1,
                    '{1'b0, 8'h00, 4'd3, 1'b0, 1'b0}};
    dir_tab[4]  = '{'{CMD_ENQ, 8'h5A, LVL_EXPIRED, 5'd1}, 1'b1,
                    '{1'b0, 8'h00, 4'd0, 1'b0, 1'b0}};
    dir_tab[5]  = '{'{CMD_ENQ, 8'h3C, LVL_EXPIRED, 5'd0}, 1'b1,
                    '{1'b0, 8'h00, 4'd0, 1'b0, 1'b0}};
    // most negative level and a plain negative one both land on level 0
    dir_tab[6]  = '{'{CMD_ENQ, 8'hC3, 5'h10, 5'd31}, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b0, 1'b0}};
    dir_tab[7]  = '{'{CMD_ENQ, 8'h81, 5'h1E, 5'd5}, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b0, 1'b0}};
    dir_tab[8]  = '{'{CMD_ENQ, 8'h7E, LVL_EXPIRED, 5'd31}, 1'b1,
                    '{1'b0, 8'h00, 4'd3, 1'b0, 1'b0}};
    dir_tab[9]  = '{'{CMD_ENQ, 8'h42, 5'd2, 5'd3}, 1'b1, '{1'b0, 8'h00, 4'd2, 1'b0, 1'b0}};
    dir_tab[10] = '{'{CMD_DEQ, 8'hFF, 5'h1F, 5'd31}, 1'b1, '{1'b1, 8'hFF, 4'd3, 1'b0, 1'b0}};
    dir_tab[11] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b1, '{1'b1, 8'h42, 4'd2, 1'b0, 1'b0}};
    dir_tab[12] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b1, '{1'b1, 8'h00, 4'd0, 1'b0, 1'b0}};
    dir_tab[13] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    dir_tab[14] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    // active side drained: swap brings the expired tasks in
    dir_tab[15] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    dir_tab[16] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    dir_tab[17] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    dir_tab[18] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    dir_tab[19] = '{'{CMD_DEQ, 8'h00, 5'd0, 5'd0}, 1'b0, '0};
    dir_tab[20] = '{'{CMD_ENQ, 8'h01, 5'd1, 5'd2}, 1'b0, '0};
    dir_tab[21] = '{'{CMD_DEQ, 8'hFF, 5'h0F, 5'd16}, 1'b0, '0};

    phase_lv[0] = 5'd16;
    phase_lv[1] = 5'd1;
    phase_lv[2] = 5'd31;
    phase_lv[3] = 5'd0;
    phase_lv[4] = 5'd17;
    phase_lv[5] = 5'd8;
    phase_lv[6] = 5'd2;
    phase_lv[7] = 5'($urandom_range(0, 31));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      pace();
      issue(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_levels(phase_lv[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (fill_left > 0) begin
          c = fill_cmd;
          fill_left--;
        end else if (pick < 3) begin
          // hammer one fifo past full
          fill_left = $urandom_range(16, 20);
          fill_cmd.mode = CMD_ENQ;
          if ($urandom_range(0, 1) == 0) begin
            fill_cmd.cur  = LVL_EXPIRED;
            fill_cmd.base = 5'($urandom_range(1, 16));
          end else begin
            fill_cmd.cur  = 5'($urandom_range(0, 15));
            fill_cmd.base = 5'($urandom_range(1, 16));
          end
          c = fill_cmd;
        end else if (pick < 50) begin
          c.mode = CMD_ENQ;
          c.cur  = ($urandom_range(0, 3) == 0) ? LVL_EXPIRED : 5'($urandom_range(0, 15));
          c.base = 5'($urandom_range(1, 16));
        end else if (pick < 58) begin
          c.mode = CMD_ENQ;
          c.cur  = 5'($urandom);
          c.base = 5'($urandom);
        end else begin
          c.mode = CMD_DEQ;
          c.cur  = 5'($urandom);
          c.base = 5'($urandom);
        end
        c.tid = ID_W'($urandom);
        pace();
        issue(c, 1'b0, '0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (due_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
